/* design/vtpd_pkg.sv */
// Shared types and constants for the vertex transform with perspective divide.
package vtpd_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned XW        = 32;
  localparam int unsigned PW        = 2 * XW;
  localparam int unsigned FW        = PW - FRAC_BITS;
  localparam int unsigned HW        = FW + 1;
  localparam int unsigned SW        = FW + 2;
  localparam int unsigned NW        = SW + FRAC_BITS;
  localparam int unsigned QW        = XW + 1;
  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 64;
  localparam int unsigned DIV_STEPS = QW;
  localparam int unsigned LAT       = 5 + DIV_STEPS + 1;

  localparam logic [CFG_DAT_W-1:0] ONE_LO = CFG_DAT_W'(64'd1 << FRAC_BITS);
  localparam logic [CFG_DAT_W-1:0] ONE_HI = CFG_DAT_W'(64'd1 << (FRAC_BITS + 32));

  typedef struct packed {
    logic signed [XW-1:0] in_x;
    logic signed [XW-1:0] in_y;
    logic signed [XW-1:0] in_z;
  } in_item_t;

  typedef struct packed {
    logic signed [XW-1:0] out_x;
    logic signed [XW-1:0] out_y;
    logic signed [XW-1:0] out_z;
    logic                 w_was_zero;
  } out_item_t;

  typedef struct packed {
    logic          neg;
    logic          over;
    logic [NW-1:0] num;
    logic [SW-1:0] rem;
    logic [QW-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    logic                   wz;
    logic [2:0][XW-1:0]     sat;
    logic [SW-1:0]          den;
    div_lane_t [2:0]        lane;
  } div_stage_t;

endpackage

/* design/vertex_transform_persp_divide.sv */
// Top level: 4x4 vertex transform with a pipelined perspective divide.
// Throughput is one vertex per cycle unless the output stalls: five arithmetic
// stages, one divide stage per quotient bit (33 of them) and an output stage,
// each a register stage.
// A stalled output holds the pipe; empty stages still fill behind it.
// Reset clears all valid bits and loads the identity matrix.
module vertex_transform_persp_divide import vtpd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  logic [NUM_REGS-1:0][CFG_DAT_W-1:0] mat_q;
  logic signed [XW-1:0]               mat [4][4];

  logic [LAT-1:0] vld_q;
  logic [LAT-1:0] en;

  logic signed [PW-1:0] prod_q  [3][4];
  logic signed [XW-1:0] trans_q [4];
  logic signed [HW-1:0] pa_q    [4];
  logic signed [HW-1:0] pb_q    [4];
  logic signed [SW-1:0] sum_q   [4];
  logic [2:0]           neg_q;
  logic [SW-1:0]        mag_q   [3];
  logic [SW-1:0]        den_q;
  logic                 wz_q;
  logic [2:0][XW-1:0]   sat_q;
  div_stage_t           dst_q   [DIV_STEPS+1];
  out_item_t            out_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q[0] <= ONE_LO;
      mat_q[1] <= '0;
      mat_q[2] <= ONE_HI;
      mat_q[3] <= '0;
      mat_q[4] <= '0;
      mat_q[5] <= ONE_LO;
      mat_q[6] <= '0;
      mat_q[7] <= ONE_HI;
    end else if (cfg_valid_i && (cfg_index_i < CFG_IDX_W'(NUM_REGS))) begin
      mat_q[cfg_index_i[2:0]] <= cfg_data_i;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        mat[r][c] = (c % 2 == 1) ? mat_q[r*2 + c/2][63:32] : mat_q[r*2 + c/2][31:0];
      end
    end
  end

  always_comb begin
    en[LAT-1] = !vld_q[LAT-1] || out_ready_i;
    for (int k = LAT - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < LAT; k++) begin
        if (en[k]) begin
          vld_q[k] <= (k == 0) ? in_valid_i : vld_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  // Products and translation.
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int c = 0; c < 4; c++) begin
        prod_q[0][c] <= PW'(in_data_i.in_x) * PW'(mat[0][c]);
        prod_q[1][c] <= PW'(in_data_i.in_y) * PW'(mat[1][c]);
        prod_q[2][c] <= PW'(in_data_i.in_z) * PW'(mat[2][c]);
        trans_q[c]   <= mat[3][c];
      end
    end
  end

  // Floor shift and pairwise sums.
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int c = 0; c < 4; c++) begin
        pa_q[c] <= HW'(FW'(prod_q[0][c] >>> FRAC_BITS)) +
                   HW'(FW'(prod_q[1][c] >>> FRAC_BITS));
        pb_q[c] <= HW'(FW'(prod_q[2][c] >>> FRAC_BITS)) + HW'(trans_q[c]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int c = 0; c < 4; c++) begin
        sum_q[c] <= SW'(pa_q[c]) + SW'(pb_q[c]);
      end
    end
  end

  // Magnitudes, signs, zero test and undivided saturation.
  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int c = 0; c < 3; c++) begin
        neg_q[c] <= sum_q[c][SW-1] ^ sum_q[3][SW-1];
        mag_q[c] <= sum_q[c][SW-1] ? (~sum_q[c] + SW'(1)) : sum_q[c];
        if (sum_q[c] > SW'(64'sd2147483647)) begin
          sat_q[c] <= 32'h7FFF_FFFF;
        end else if (sum_q[c] < -SW'(64'sd2147483648)) begin
          sat_q[c] <= 32'h8000_0000;
        end else begin
          sat_q[c] <= sum_q[c][XW-1:0];
        end
      end
      den_q <= sum_q[3][SW-1] ? (~sum_q[3] + SW'(1)) : sum_q[3];
      wz_q  <= (sum_q[3] == '0);
    end
  end

  // Overflow precheck and initial partial remainder.
  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      dst_q[0].wz  <= wz_q;
      dst_q[0].sat <= sat_q;
      dst_q[0].den <= den_q;
      for (int c = 0; c < 3; c++) begin
        dst_q[0].lane[c].neg  <= neg_q[c];
        dst_q[0].lane[c].num  <= {mag_q[c], FRAC_BITS'(0)};
        dst_q[0].lane[c].over <= SW'(mag_q[c] >> (QW - FRAC_BITS)) >= den_q;
        dst_q[0].lane[c].rem  <= SW'(mag_q[c] >> (QW - FRAC_BITS));
        dst_q[0].lane[c].quo  <= '0;
      end
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    localparam int unsigned Bit = DIV_STEPS - 1 - g;
    always_ff @(posedge clk_i) begin
      if (en[5+g]) begin
        dst_q[g+1].wz  <= dst_q[g].wz;
        dst_q[g+1].sat <= dst_q[g].sat;
        dst_q[g+1].den <= dst_q[g].den;
        for (int c = 0; c < 3; c++) begin
          logic [SW:0] trial;
          trial = {dst_q[g].lane[c].rem, dst_q[g].lane[c].num[Bit]};
          dst_q[g+1].lane[c].neg  <= dst_q[g].lane[c].neg;
          dst_q[g+1].lane[c].over <= dst_q[g].lane[c].over;
          dst_q[g+1].lane[c].num  <= dst_q[g].lane[c].num;
          if (trial >= {1'b0, dst_q[g].den}) begin
            dst_q[g+1].lane[c].rem <= SW'(trial - {1'b0, dst_q[g].den});
            dst_q[g+1].lane[c].quo <= {dst_q[g].lane[c].quo[QW-2:0], 1'b1};
          end else begin
            dst_q[g+1].lane[c].rem <= trial[SW-1:0];
            dst_q[g+1].lane[c].quo <= {dst_q[g].lane[c].quo[QW-2:0], 1'b0};
          end
        end
      end
    end
  end

  // Sign, saturation and output register.
  always_ff @(posedge clk_i) begin
    if (en[LAT-1]) begin
      logic [2:0][XW-1:0] res;
      div_stage_t         s;
      s = dst_q[DIV_STEPS];
      for (int c = 0; c < 3; c++) begin
        if (s.wz) begin
          res[c] = s.sat[c];
        end else if (s.lane[c].neg) begin
          if (s.lane[c].over || (s.lane[c].quo > QW'(33'h0_8000_0000))) begin
            res[c] = 32'h8000_0000;
          end else begin
            res[c] = XW'(~s.lane[c].quo + QW'(1));
          end
        end else if (s.lane[c].over || s.lane[c].quo[QW-1] || s.lane[c].quo[XW-1]) begin
          res[c] = 32'h7FFF_FFFF;
        end else begin
          res[c] = s.lane[c].quo[XW-1:0];
        end
      end
      out_q.out_x      <= res[0];
      out_q.out_y      <= res[1];
      out_q.out_z      <= res[2];
      out_q.w_was_zero <= s.wz;
    end
  end

  assign out_valid_o = vld_q[LAT-1];
  assign out_data_o  = out_q;

endmodule

/* design/vtpd_checker.sv */
// Port-level checker for the vertex transform, with its bind statement.
module vtpd_assertions import vtpd_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o,
  input logic      cfg_valid_i,
  input logic      cfg_ready_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed");

  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input not ready while output drains");

  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input not ready with an empty output stage");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration beat not accepted at once");

endmodule

bind vertex_transform_persp_divide vtpd_assertions u_vtpd_checker (.*);

/* dv/vtpd_checker.sv */
// Checker for the vertex transform: tracks the matrix, predicts each vertex and compares.
module vtpd_checker import vtpd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  in_item_t             in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  out_item_t            out_data_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  output int                   errors_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [CFG_DAT_W-1:0] matrix_q [NUM_REGS];
  out_item_t            vertex_q [$];

  function automatic longint entry(int r, int c);
    logic [CFG_DAT_W-1:0] word;
    word = matrix_q[r * 2 + c / 2];
    return (c % 2) ? longint'($signed(word[63:32])) : longint'($signed(word[31:0]));
  endfunction

  function automatic logic [XW-1:0] clamp(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[XW-1:0];
  endfunction

  function automatic logic [XW-1:0] persp_div(longint num, longint den);
    logic         neg;
    logic [127:0] n;
    logic [127:0] d;
    logic [127:0] q;
    neg = (num < 0) != (den < 0);
    n = 128'(num < 0 ? -num : num) << FRAC_BITS;
    d = 128'(den < 0 ? -den : den);
    q = n / d;
    if (neg) return (q > 128'h8000_0000) ? 32'h8000_0000 : -q[XW-1:0];
    return (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[XW-1:0];
  endfunction

  function automatic out_item_t transform(in_item_t v);
    longint    pt [3];
    longint    col [4];
    out_item_t res;
    pt[0] = longint'(v.in_x);
    pt[1] = longint'(v.in_y);
    pt[2] = longint'(v.in_z);
    for (int j = 0; j < 4; j++) begin
      col[j] = entry(3, j);
      for (int i = 0; i < 3; i++) col[j] += (pt[i] * entry(i, j)) >>> FRAC_BITS;
    end
    res.w_was_zero = (col[3] == 0);
    res.out_x = res.w_was_zero ? clamp(col[0]) : persp_div(col[0], col[3]);
    res.out_y = res.w_was_zero ? clamp(col[1]) : persp_div(col[1], col[3]);
    res.out_z = res.w_was_zero ? clamp(col[2]) : persp_div(col[2], col[3]);
    return res;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        matrix_q[i] <= (i == 0 || i == 5) ? ONE_LO : (i == 2 || i == 7) ? ONE_HI : '0;
      end
      errors_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i && cfg_index_i < NUM_REGS) begin
        matrix_q[cfg_index_i[2:0]] <= cfg_data_i;
      end
      if (in_valid_i && in_ready_i) vertex_q.push_back(transform(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (vertex_q.size() == 0) begin
          $display("%t: unexpected beat, actual %h", $time, out_data_i);
          errors_o <= errors_o + 1;
        end else begin
          want = vertex_q.pop_front();
          if (want.out_x !== out_data_i.out_x || want.out_y !== out_data_i.out_y ||
              want.out_z !== out_data_i.out_z || want.w_was_zero !== out_data_i.w_was_zero) begin
            $display("%t: mismatch, expected x=%h y=%h z=%h wz=%b, actual x=%h y=%h z=%h wz=%b",
                     $time, want.out_x, want.out_y, want.out_z, want.w_was_zero,
                     out_data_i.out_x, out_data_i.out_y, out_data_i.out_z,
                     out_data_i.w_was_zero);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = vertex_q.size();

endmodule

/* dv/tb_vertex_transform_persp_divide.sv */
// Testbench top: drives vertices and matrix writes, and gives the verdict.
module tb_vertex_transform_persp_divide;
  import vtpd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          STALL_LIMIT = 20000;
  localparam int          PHASE_ITEMS = 180;
  localparam int          BAD_INDEX   = 8;
  localparam int          TOP_INDEX   = 255;
  localparam logic [31:0] FX_ONE      = 32'h0001_0000;
  localparam logic [31:0] FX_MAX      = 32'h7FFF_FFFF;
  localparam logic [31:0] FX_MIN      = 32'h8000_0000;

  typedef enum int {
    PH_GENERAL, PH_PERSPECTIVE, PH_ALL_MAX, PH_ALL_MIN, PH_ZERO_W, PH_STEEP, PH_COUNT
  } phase_e;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  int                   errors;
  int                   pending;
  int                   quiet_cycles = 0;
  logic                 calm = 1'b0;
  logic [31:0]          mat [4][4];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  vertex_transform_persp_divide u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  vtpd_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 16);
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles > STALL_LIMIT) begin
      $display("vertex_transform_persp_divide test failed");
      $finish;
    end
  end

  task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    if (!calm && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{in_x: x, in_y: y, in_z: z};
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  task automatic write_reg(int idx, logic [CFG_DAT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data  <= value;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
  endtask

  task automatic load_matrix();
    for (int r = 0; r < 4; r++) begin
      for (int h = 0; h < 2; h++) write_reg(r * 2 + h, {mat[r][2 * h + 1], mat[r][2 * h]});
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (LAT + 8) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_value(int bias);
    case ($urandom_range(bias, 3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      2: return ($urandom_range(0, 16) - 8) << 16;
      default: begin
        case ($urandom_range(4))
          0: return FX_MAX;
          1: return FX_MIN;
          2: return 32'hFFFF_FFFF;
          3: return FX_ONE;
          default: return '0;
        endcase
      end
    endcase
  endfunction

  task automatic build_matrix(phase_e ph);
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        case (ph)
          PH_ALL_MAX: mat[r][c] = FX_MAX;
          PH_ALL_MIN: mat[r][c] = FX_MIN;
          PH_ZERO_W: mat[r][c] = (c == 3) ? '0 : rand_value(0);
          PH_STEEP: mat[r][c] = (c == 3) ? $urandom_range(0, 64) - 32 : rand_value(1);
          default: mat[r][c] = rand_value(1);
        endcase
      end
    end
    if (ph == PH_PERSPECTIVE) begin
      mat[0][3] = '0;
      mat[1][3] = '0;
      mat[2][3] = $urandom_range(1) ? FX_ONE : -FX_ONE;
      mat[3][3] = '0;
    end
  endtask

  initial begin
    logic [31:0] edge_vals [6];
    logic [31:0] z;
    edge_vals = '{32'h0, FX_MAX, FX_MIN, 32'hFFFF_FFFF, FX_ONE, 32'h5555_AAAA};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 6; i++) send_vertex(edge_vals[i], edge_vals[(i + 1) % 6],
                                            edge_vals[(i + 2) % 6]);
    drain();

    // Perspective matrix: w follows z, so z of zero gives the undivided case.
    build_matrix(PH_PERSPECTIVE);
    mat[2][3] = FX_ONE;
    load_matrix();
    cfg_valid <= 1'b0;
    for (int i = 0; i < 6; i++) send_vertex(edge_vals[i], edge_vals[5 - i], edge_vals[i]);
    send_vertex(FX_MAX, FX_MIN, '0);
    send_vertex(FX_MIN, FX_MAX, '0);
    send_vertex(FX_ONE, FX_ONE, 32'h0000_0001);
    send_vertex(FX_MAX, FX_MAX, 32'hFFFF_FFFF);
    drain();

    for (int p = 0; p < PH_COUNT; p++) begin
      calm = (p == PH_ALL_MAX);
      build_matrix(phase_e'(p));
      load_matrix();
      if (p == PH_ALL_MAX) begin
        write_reg(BAD_INDEX, '0);
        write_reg(TOP_INDEX, '1);
      end
      cfg_valid <= 1'b0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        z = (p == PH_PERSPECTIVE && $urandom_range(3) == 0) ? '0 : rand_value(0);
        send_vertex(rand_value(0), rand_value(0), z);
      end
      drain();
    end
    calm = 1'b0;

    if (errors == 0) begin
      $display("vertex_transform_persp_divide test passed");
    end else begin
      $display("vertex_transform_persp_divide test failed");
    end
    $finish;
  end

endmodule
